// File: hw/rtl/cbq_pkg.sv
// Shared types, codes and saturation helper for the cascaded biquad filter.
`default_nettype none

package cbq_pkg;

  localparam int COEF_W    = 32;
  localparam int DELAY_W   = 40;
  localparam int ACC_W     = 48;
  localparam int FRAC_SHIFT = 28;

  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [DELAY_W-1:0] delay_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  // Item kinds carried in tuser
  localparam logic [1:0] MODE_FILTER = 2'd0;
  localparam logic [1:0] MODE_COEF   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // Coefficient selectors
  localparam logic [2:0] SEL_A1 = 3'd0;
  localparam logic [2:0] SEL_A2 = 3'd1;
  localparam logic [2:0] SEL_B0 = 3'd2;
  localparam logic [2:0] SEL_B1 = 3'd3;
  localparam logic [2:0] SEL_B2 = 3'd4;

  localparam acc_t DELAY_MAX = 48'sd549755813887;
  localparam acc_t DELAY_MIN = -48'sd549755813888;

  // Value handed from one section cell to the next
  typedef struct packed {
    logic   go;
    delay_t x;
  } link_t;

  // Coefficient write broadcast to all cells
  typedef struct packed {
    logic       en;
    logic [3:0] section;
    logic [2:0] sel;
    coef_t      value;
  } coef_wr_t;

  function automatic delay_t sat40(input acc_t v);
    delay_t r;
    if (v > DELAY_MAX) begin
      r = DELAY_MAX[DELAY_W-1:0];
    end else if (v < DELAY_MIN) begin
      r = DELAY_MIN[DELAY_W-1:0];
    end else begin
      r = v[DELAY_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cascaded_biquad_iir_filter_core.sv
// Top level of the cascaded biquad IIR filter: stream ports, section chain, output rounding.
//
// A filter item (tuser 0) walks through the first active_sections section cells, one cell
// at a time; each cell runs its five coefficient products through its own split multiplier,
// one product per cycle. Only one sample is in the chain at a time; the next input transfer
// is taken once the result sits in the output register, even while that result waits for
// out_tready. Coefficient writes (tuser 1) and clears (tuser 2) give no result.
// Coefficients have no reset value and must be written before a section is used; delays
// reset to zero.
`default_nettype none

module cascaded_biquad_iir_filter_core
  import cbq_pkg::*;
#(
  parameter int MAX_SECTIONS = 16,
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_tvalid,
  output logic                                         in_tready,
  // sample_in, section_index, coeff_select, coeff_value, zero pad
  input  wire logic [((SAMPLE_WIDTH+39+7)/8)*8-1:0]    in_tdata,
  // mode
  input  wire logic [1:0]                              in_tuser,
  output logic                                         out_tvalid,
  input  wire logic                                    out_tready,
  // sample_out, zero pad
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]            out_tdata,
  input  wire logic                                    cfg_wr_en,
  input  wire logic [4:0]                              cfg_wr_data
);

  localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int SW    = SAMPLE_WIDTH;
  localparam int SHIFT = 32 - SAMPLE_WIDTH;
  localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam logic signed [DELAY_W:0] OUT_MAX = (41'sd1 <<< (SW - 1)) - 41'sd1;
  localparam logic signed [DELAY_W:0] OUT_MIN = -(41'sd1 <<< (SW - 1));

  logic                 in_acc;
  logic signed [SW-1:0] in_sample;
  delay_t               x0;
  coef_wr_t             coef_wr;
  logic                 clr;

  logic                 busy_r, pend_r, out_valid_r, go0_r;
  logic [4:0]           active_r;
  delay_t               x0_r;
  logic [SW-1:0]        res_r, res_nxt, out_data_r;
  logic [IDX_W-1:0]     last_idx;
  logic                 slot_free, fin;
  delay_t               fin_x;
  logic signed [DELAY_W:0] fin_q;

  link_t                link_in  [MAX_SECTIONS];
  link_t                link_out [MAX_SECTIONS];
  logic [MAX_SECTIONS-1:0] go_vec;

  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && in_tready;
  assign in_sample = $signed(in_tdata[SW-1:0]);
  assign x0        = DELAY_W'(in_sample) <<< SHIFT;

  assign coef_wr.en      = in_acc && (in_tuser == MODE_COEF);
  assign coef_wr.section = in_tdata[SW+3:SW];
  assign coef_wr.sel     = in_tdata[SW+6:SW+4];
  assign coef_wr.value   = $signed(in_tdata[SW+38:SW+7]);
  assign clr             = in_acc && (in_tuser == MODE_CLEAR);

  // Zero sections act as one, too many act as all
  always_comb begin
    if (active_r == 5'd0) begin
      last_idx = '0;
    end else if ({1'b0, active_r} > 6'(MAX_SECTIONS)) begin
      last_idx = IDX_W'(MAX_SECTIONS - 1);
    end else begin
      last_idx = IDX_W'(active_r - 5'd1);
    end
  end

  assign link_in[0].go = go0_r;
  assign link_in[0].x  = x0_r;

  for (genvar s = 0; s < MAX_SECTIONS; s++) begin : g_cell
    if (s > 0) begin : g_link
      // stop the chain after the last active section
      assign link_in[s].go = link_out[s-1].go && (last_idx != IDX_W'(s - 1));
      assign link_in[s].x  = link_out[s-1].x;
    end
    assign go_vec[s] = link_in[s].go;

    cbq_cell #(
      .CELL_ID (s)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .link_i    (link_in[s]),
      .coef_wr_i (coef_wr),
      .clr_i     (clr),
      .link_o    (link_out[s])
    );
  end

  assign fin   = link_out[last_idx].go;
  assign fin_x = link_out[last_idx].x;

  if (SHIFT > 0) begin : g_rnd
    logic signed [DELAY_W:0] fin_rnd;
    assign fin_rnd = (DELAY_W+1)'(fin_x) + (41'sd1 <<< (SHIFT - 1));
    assign fin_q   = fin_rnd >>> SHIFT;
  end else begin : g_nornd
    assign fin_q = (DELAY_W+1)'(fin_x);
  end

  assign res_nxt = (fin_q > OUT_MAX) ? OUT_MAX[SW-1:0] :
                   (fin_q < OUT_MIN) ? OUT_MIN[SW-1:0] : fin_q[SW-1:0];

  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      go0_r       <= 1'b0;
      active_r    <= 5'd1;
    end else begin
      go0_r <= in_acc && (in_tuser == MODE_FILTER);
      if (cfg_wr_en) begin
        active_r <= cfg_wr_data;
      end
      if (in_acc && (in_tuser == MODE_FILTER)) begin
        busy_r <= 1'b1;
      end
      if (fin) begin
        pend_r <= 1'b1;
      end
      // move the finished result into the output register
      if (pend_r && slot_free) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
        busy_r      <= 1'b0;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x0_r <= x0;
    end
    if (fin) begin
      res_r <= res_nxt;
    end
    if (pend_r && slot_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);

`ifndef SYNTHESIS
  a_one_cell: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(go_vec))
    else $error("more than one section cell started in one cycle");

  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> busy_r && !pend_r)
    else $error("chain finished with no sample in flight");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !pend_r && !go0_r)
    else $error("result pending while input side is open");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/cbq_mul.sv
// Q3.28 by Q8.31 product split into two registered partial products, rounded to Q8.31.
`default_nettype none

module cbq_mul
  import cbq_pkg::*;
(
  input  wire logic   clk,
  input  wire coef_t  coef_i,
  input  wire delay_t data_i,
  output acc_t        prod_o
);

  localparam int LO_W  = COEF_W + FRAC_SHIFT + 1;
  localparam int HI_W  = COEF_W + DELAY_W - FRAC_SHIFT;
  localparam logic signed [LO_W-1:0] RND_LO = {{(LO_W-1){1'b0}}, 1'b1} <<< (FRAC_SHIFT - 1);

  logic signed [LO_W-1:0] plo_nxt, plo_r, plo_rnd;
  logic signed [HI_W-1:0] phi_nxt, phi_r;

  // Low part is the unsigned low FRAC_SHIFT data bits, high part the signed upper data bits
  assign plo_nxt = coef_i * $signed({1'b0, data_i[FRAC_SHIFT-1:0]});
  assign phi_nxt = coef_i * $signed(data_i[DELAY_W-1:FRAC_SHIFT]);

  always_ff @(posedge clk) begin
    plo_r <= plo_nxt;
    phi_r <= phi_nxt;
  end

  assign plo_rnd = plo_r + RND_LO;
  assign prod_o  = ACC_W'(phi_r) + ACC_W'($signed(plo_rnd[LO_W-1:FRAC_SHIFT]));

endmodule

`default_nettype wire

// File: hw/rtl/cbq_cell.sv
// One biquad section: coefficients, two delays and a six-step product sequencer.
`default_nettype none

module cbq_cell
  import cbq_pkg::*;
#(
  parameter int CELL_ID = 0
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire link_t    link_i,
  input  wire coef_wr_t coef_wr_i,
  input  wire logic     clr_i,
  output link_t         link_o
);

  typedef enum logic [2:0] {
    ST_A1, ST_A2, ST_B1, ST_B0, ST_B2, ST_Y
  } step_t;

  step_t  step_r, cur, step_nxt;
  logic   run_r, act;
  coef_t  a1_r, a2_r, b0_r, b1_r, b2_r;
  delay_t w1_r, w2_r, wn_r, x_r;
  acc_t   acc_r, prod;
  coef_t  mul_c;
  delay_t mul_d;
  logic   go_r;
  delay_t y_r;
  logic   wr_hit;

  assign cur    = link_i.go ? ST_A1 : step_r;
  assign act    = link_i.go | run_r;
  assign wr_hit = coef_wr_i.en && (int'(coef_wr_i.section) == CELL_ID);

  always_comb begin
    step_nxt = ST_A1;
    mul_c    = a1_r;
    mul_d    = w1_r;
    case (cur)
      ST_A1: begin
        step_nxt = ST_A2;
        mul_c    = a1_r;
        mul_d    = w1_r;
      end
      ST_A2: begin
        step_nxt = ST_B1;
        mul_c    = a2_r;
        mul_d    = w2_r;
      end
      ST_B1: begin
        step_nxt = ST_B0;
        mul_c    = b1_r;
        mul_d    = w1_r;
      end
      ST_B0: begin
        step_nxt = ST_B2;
        mul_c    = b0_r;
        mul_d    = wn_r;
      end
      ST_B2: begin
        step_nxt = ST_Y;
        mul_c    = b2_r;
        mul_d    = w2_r;
      end
      ST_Y: begin
        step_nxt = ST_A1;
      end
      default: begin
        step_nxt = ST_A1;
      end
    endcase
  end

  cbq_mul u_mul (
    .clk    (clk),
    .coef_i (mul_c),
    .data_i (mul_d),
    .prod_o (prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_A1;
      run_r  <= 1'b0;
      go_r   <= 1'b0;
      w1_r   <= '0;
      w2_r   <= '0;
    end else begin
      go_r <= act && (cur == ST_Y);
      if (link_i.go) begin
        x_r <= link_i.x;
      end
      if (act) begin
        step_r <= step_nxt;
        run_r  <= (cur != ST_Y);
        case (cur)
          ST_A2:   acc_r <= ACC_W'(x_r) + prod;
          ST_B1:   wn_r  <= sat40(acc_r + prod);
          ST_B0:   acc_r <= prod;
          ST_B2:   acc_r <= acc_r + prod;
          ST_Y: begin
            // hand the section output on and advance the delays
            y_r  <= sat40(acc_r + prod);
            w2_r <= w1_r;
            w1_r <= wn_r;
          end
          default: ;
        endcase
      end
      if (clr_i) begin
        w1_r <= '0;
        w2_r <= '0;
      end
      if (wr_hit) begin
        case (coef_wr_i.sel)
          SEL_A1:  a1_r <= coef_wr_i.value;
          SEL_A2:  a2_r <= coef_wr_i.value;
          SEL_B0:  b0_r <= coef_wr_i.value;
          SEL_B1:  b1_r <= coef_wr_i.value;
          SEL_B2:  b2_r <= coef_wr_i.value;
          default: ;
        endcase
      end
    end
  end

  assign link_o.go = go_r;
  assign link_o.x  = y_r;

`ifndef SYNTHESIS
  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    link_i.go |-> !run_r)
    else $error("sample arrived at a busy section cell");

  a_handoff_idle: assert property (@(posedge clk) disable iff (!rst_n)
    go_r |-> !run_r && step_r == ST_A1)
    else $error("section cell still running after handing on its output");
`endif

endmodule

`default_nettype wire

// File: verif/tb_cascaded_biquad_iir_filter_core.sv
// Testbench for the cascaded biquad IIR filter core: directed table, random phases, checker.
module tb_cascaded_biquad_iir_filter_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cbq_pkg::*;

  localparam int SECTIONS        = 16;
  localparam int NUM_COEF        = 5;
  localparam int SAMPLE_W        = 24;
  localparam int IN_W            = 64;
  localparam int SETTLE_CYCLES   = 6 * SECTIONS + 3 + 30;
  localparam int LONG_HOLD       = 600;
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 205;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] SEL_BAD_LO  = 3'd5;
  localparam logic [2:0] SEL_BAD_HI  = 3'd7;

  localparam longint Q831_MAX = 64'sd549755813887;
  localparam longint Q831_MIN = -64'sd549755813888;
  localparam longint OUT_MAX  = 64'sd8388607;
  localparam longint OUT_MIN  = -64'sd8388608;

  localparam coef_t COEF_ONE  = 32'sh1000_0000;
  localparam coef_t COEF_HALF = 32'sh0800_0000;
  localparam coef_t COEF_MAX  = 32'sh7FFF_FFFF;
  localparam coef_t COEF_MIN  = 32'sh8000_0000;

  localparam logic [4:0] PHASE_SECTIONS [PHASES] = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd16};

  typedef enum logic {ROW_ITEM, ROW_SECTIONS} row_kind_e;

  typedef struct packed {
    row_kind_e                   kind;
    logic [1:0]                  mode;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [3:0]                  section;
    logic [2:0]                  sel;
    coef_t                       value;
    logic                        typed;
    logic signed [SAMPLE_W-1:0]  want;
  } plan_row_t;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_tvalid   = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata    = '0;
  logic [1:0]           in_tuser    = '0;
  logic                 out_tvalid;
  logic                 out_tready  = 1'b0;
  logic [SAMPLE_W-1:0]  out_tdata;
  logic                 cfg_wr_en   = 1'b0;
  logic [4:0]           cfg_wr_data = '0;

  // Filter state as the block should hold it
  coef_t      coef_mem    [SECTIONS][NUM_COEF];
  bit         coef_loaded [SECTIONS][NUM_COEF];
  longint     delay_w1    [SECTIONS];
  longint     delay_w2    [SECTIONS];
  logic [4:0] sections_cfg = 5'd1;

  logic signed [SAMPLE_W-1:0] due_samples [$];

  int mismatches      = 0;
  int outputs_checked = 0;
  int coef_writes     = 0;
  int clears_sent     = 0;
  int settings_used   = 0;
  int snd_idle_pct    = 14;
  int rcv_idle_pct    = 84;
  int hold_token      = 0;
  int hold_seen       = 0;
  int hold_left       = 0;
  int cycle_count     = 0;

  cascaded_biquad_iir_filter_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_q831(longint v);
    if (v > Q831_MAX) return Q831_MAX;
    if (v < Q831_MIN) return Q831_MIN;
    return v;
  endfunction

  // Q3.28 coefficient times Q8.31 delay, rounded half up back to Q8.31
  function automatic longint coef_times(coef_t c, longint w);
    longint lo, hi, part;
    lo   = w & 64'sh0FFF_FFFF;
    hi   = w >>> FRAC_SHIFT;
    part = longint'(c) * lo + (64'sd1 <<< (FRAC_SHIFT - 1));
    return longint'(c) * hi + (part >>> FRAC_SHIFT);
  endfunction

  function automatic int eff_sections();
    if (sections_cfg == 5'd0) return 1;
    if (sections_cfg > SECTIONS) return SECTIONS;
    return int'(sections_cfg);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] run_cascade(logic signed [SAMPLE_W-1:0] s);
    longint x, w, w1, w2, r;
    x = longint'(s) * 256;
    for (int k = 0; k < eff_sections(); k++) begin
      w1 = delay_w1[k];
      w2 = delay_w2[k];
      w  = clamp_q831(x + coef_times(coef_mem[k][SEL_A1], w1)
                        + coef_times(coef_mem[k][SEL_A2], w2));
      x  = clamp_q831(coef_times(coef_mem[k][SEL_B0], w)
                    + coef_times(coef_mem[k][SEL_B1], w1)
                    + coef_times(coef_mem[k][SEL_B2], w2));
      delay_w2[k] = w1;
      delay_w1[k] = w;
    end
    r = (x + 128) >>> 8;
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < OUT_MIN) r = OUT_MIN;
    return r[SAMPLE_W-1:0];
  endfunction

  function automatic logic [IN_W-1:0] pack_item(logic signed [SAMPLE_W-1:0] s,
                                                logic [3:0] sec, logic [2:0] sel, coef_t v);
    return {1'b0, v, sel, sec, s};
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return OUT_MAX[SAMPLE_W-1:0];
    if (roll < 16) return OUT_MIN[SAMPLE_W-1:0];
    if (roll < 30) return 24'(int'($urandom_range(512)) - 256);
    return 24'($urandom);
  endfunction

  // Mostly modest coefficients so the cascade rings instead of pinning at the rails
  function automatic coef_t pick_coef(logic [2:0] sel);
    int roll;
    roll = $urandom_range(99);
    if (roll < 4) return COEF_MAX;
    if (roll < 8) return COEF_MIN;
    if (roll < 25) return coef_t'($urandom);
    if (sel == SEL_A1) return coef_t'($urandom_range(32'h2000_0000)) - COEF_ONE;
    if (sel == SEL_A2) return coef_t'($urandom_range(32'h0C00_0000)) - COEF_HALF;
    return coef_t'($urandom_range(32'h1000_0000)) - COEF_HALF;
  endfunction

  function automatic plan_row_t make_row(row_kind_e kind, logic [1:0] mode, int sample,
                                         logic [3:0] sec, logic [2:0] sel, coef_t value,
                                         bit typed, int want);
    plan_row_t r;
    r.kind    = kind;
    r.mode    = mode;
    r.sample  = 24'(sample);
    r.section = sec;
    r.sel     = sel;
    r.value   = value;
    r.typed   = typed;
    r.want    = 24'(want);
    return r;
  endfunction

  // Offer one item, hold it until the transfer, then update the expected state
  task automatic offer(logic [1:0] mode, logic [IN_W-1:0] data, bit typed,
                       logic signed [SAMPLE_W-1:0] want);
    logic signed [SAMPLE_W-1:0] y;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    case (mode)
      MODE_COEF: begin
        if (data[30:28] < NUM_COEF) begin
          coef_mem[data[27:24]][data[30:28]]    = data[62:31];
          coef_loaded[data[27:24]][data[30:28]] = 1'b1;
          coef_writes++;
        end
      end
      MODE_CLEAR: begin
        for (int k = 0; k < SECTIONS; k++) begin
          delay_w1[k] = 0;
          delay_w2[k] = 0;
        end
        clears_sent++;
      end
      MODE_FILTER: begin
        y = run_cascade(data[SAMPLE_W-1:0]);
        due_samples.push_back(typed ? want : y);
      end
      default: ;
    endcase
  endtask

  task automatic sender_gap();
    while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop valid and wait for every pending sample plus the chain's worst-case latency
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_sections(logic [4:0] count);
    wait_quiet();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    sections_cfg  = count;
    settings_used++;
  endtask

  task automatic random_item(output bit counted);
    int                         roll;
    logic [3:0]                 sec;
    logic [2:0]                 sel;
    logic signed [SAMPLE_W-1:0] s;
    coef_t                      v;
    bit                         missing;
    roll    = $urandom_range(99);
    s       = pick_sample();
    sec     = 4'($urandom_range(SECTIONS - 1));
    sel     = 3'($urandom_range(NUM_COEF - 1));
    v       = pick_coef(sel);
    counted = 1'b1;
    missing = 1'b0;
    if (roll < 14) begin
      offer(MODE_COEF, pack_item(s, sec, sel, v), 1'b0, '0);
    end else if (roll < 17) begin
      sel = 3'($urandom_range(SEL_BAD_HI, SEL_BAD_LO));
      offer(MODE_COEF, pack_item(s, sec, sel, v), 1'b0, '0);
      counted = 1'b0;
    end else if (roll < 20) begin
      offer(MODE_CLEAR, pack_item(s, sec, sel, v), 1'b0, '0);
    end else if (roll < 22) begin
      offer(MODE_UNUSED, pack_item(s, sec, sel, v), 1'b0, '0);
      counted = 1'b0;
    end else begin
      // Load any coefficient the active sections still lack before filtering
      for (int k = 0; k < eff_sections(); k++) begin
        for (int c = 0; c < NUM_COEF; c++) begin
          if (!missing && !coef_loaded[k][c]) begin
            missing = 1'b1;
            sec     = 4'(k);
            sel     = 3'(c);
          end
        end
      end
      if (missing) offer(MODE_COEF, pack_item(s, sec, sel, pick_coef(sel)), 1'b0, '0);
      else offer(MODE_FILTER, pack_item(s, sec, sel, v), 1'b0, '0);
    end
    sender_gap();
  endtask

  always @(posedge clk) begin : take_output
    logic signed [SAMPLE_W-1:0] want;
    if (out_tvalid && out_tready) begin
      if (due_samples.size() == 0) begin
        $display("%0t: unexpected sample_out %0d", $time, $signed(out_tdata));
        mismatches++;
      end else begin
        want = due_samples.pop_front();
        outputs_checked++;
        if (out_tdata !== want) begin
          $display("%0t: sample_out mismatch, expected %0d, got %0d",
                   $time, want, $signed(out_tdata));
          mismatches++;
        end
      end
    end
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    plan_row_t plan [$];
    bit        counted;
    int        made;

    // Section 0 as a straight wire first, then the rails, ignored items and saturation
    plan.push_back(make_row(ROW_ITEM, MODE_COEF, 0, 4'd0, SEL_A1, 32'sd0, 1'b0, 0));
    plan.push_back(make_row(ROW_ITEM, MODE_COEF, 0, 4'd0, SEL_A2, 32'sd0, 1'b0, 0));
    plan.push_back(make_row(ROW_ITEM, MODE_COEF, 0, 4'd0, SEL_B0, COEF_ONE, 1'b0, 0));
    plan.push_back(make_row(ROW_ITEM, MODE_COEF, 0, 4'd0, SEL_B1, 32'sd0, 1'b0, 0));
    plan.push_back(make_row(ROW_ITEM, MODE_COEF, 0, 4'd0, SEL_B2, 32'sd0, 1'b0, 0));
    plan.push_back(make_row(ROW_ITEM, MODE_FILTER, 8388607, 4'd0, SEL_A1, 32'sd0, 1'b1, 8388607));
    plan.push_back(make_row(ROW_ITEM, MODE_FILTER, -8388608, 4'd0, SEL_A1, 32'sd0, 1'b1, -8388608));
    plan.push_back(make_row(ROW_ITEM, MODE_FILTER, 0, 4'd0, SEL_A1, 32'sd0, 1'b1, 0));
    plan.push_back(make_row(ROW_ITEM, MODE_COEF, 0, 4'd15, SEL_BAD_LO, 32'sh1234_5678, 1'b0, 0));
    plan.push_back(make_row(ROW_ITEM, MODE_COEF, 0, 4'd0, SEL_BAD_HI, COEF_MAX, 1'b0, 0));
    plan.push_back(make_row(ROW_ITEM, MODE_UNUSED, -1, 4'd15, SEL_BAD_HI, COEF_MIN, 1'b0, 0));
    plan.push_back(make_row(ROW_ITEM, MODE_FILTER, 1, 4'd15, SEL_BAD_HI, COEF_MIN, 1'b1, 1));
    plan.push_back(make_row(ROW_ITEM, MODE_COEF, 0, 4'd0, SEL_B0, COEF_MAX, 1'b0, 0));
    plan.push_back(make_row(ROW_ITEM, MODE_FILTER, 8388607, 4'd0, SEL_A1, 32'sd0, 1'b1, 8388607));
    plan.push_back(make_row(ROW_ITEM, MODE_FILTER, -8388608, 4'd0, SEL_A1, 32'sd0, 1'b1, -8388608));
    plan.push_back(make_row(ROW_ITEM, MODE_CLEAR, 0, 4'd0, SEL_A1, 32'sd0, 1'b0, 0));
    plan.push_back(make_row(ROW_ITEM, MODE_COEF, 0, 4'd0, SEL_B1, COEF_MIN, 1'b0, 0));
    plan.push_back(make_row(ROW_ITEM, MODE_COEF, 0, 4'd0, SEL_A1, COEF_MAX, 1'b0, 0));
    plan.push_back(make_row(ROW_ITEM, MODE_FILTER, 8388607, 4'd0, SEL_A1, 32'sd0, 1'b0, 0));
    plan.push_back(make_row(ROW_ITEM, MODE_FILTER, 12345, 4'd0, SEL_A1, 32'sd0, 1'b0, 0));
    plan.push_back(make_row(ROW_SECTIONS, MODE_FILTER, 0, 4'd0, SEL_A1, 32'sd0, 1'b0, 0));
    plan.push_back(make_row(ROW_ITEM, MODE_FILTER, -77777, 4'd0, SEL_A1, 32'sd0, 1'b0, 0));
    plan.push_back(make_row(ROW_ITEM, MODE_CLEAR, 0, 4'd0, SEL_A1, 32'sd0, 1'b0, 0));
    plan.push_back(make_row(ROW_ITEM, MODE_FILTER, 0, 4'd0, SEL_A1, 32'sd0, 1'b1, 0));
    plan.push_back(make_row(ROW_ITEM, MODE_COEF, 0, 4'd15, SEL_B2, COEF_MIN, 1'b0, 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SECTIONS) begin
        set_sections(plan[i].value[4:0]);
      end else begin
        offer(plan[i].mode,
              pack_item(plan[i].sample, plan[i].section, plan[i].sel, plan[i].value),
              plan[i].typed, plan[i].want);
        sender_gap();
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 2) begin
        snd_idle_pct = 84;
        rcv_idle_pct = 14;
      end else if (p == 4) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      set_sections(PHASE_SECTIONS[p]);
      // Stall the output for a long stretch so the input backs up
      if (p == 4) hold_token++;
      made = 0;
      while (made < ITEMS_PER_PHASE) begin
        random_item(counted);
        if (counted) begin
          made++;
          if (made == ITEMS_PER_PHASE / 2) wait_quiet();
        end
      end
    end

    wait_quiet();
    $display("Checked %0d filtered samples across %0d section-count settings (0 to 31).",
             outputs_checked, settings_used);
    $display("Sent %0d coefficient loads and %0d delay clears under varied stalls.",
             coef_writes, clears_sent);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
